FILE: rtl/cgsc_pkg.sv
// Shared types, constants and the divider step function of the skin classifier.
package cgsc_pkg;

   localparam int NumChan = 3;
   localparam int PixW = 8;
   localparam int DenW = 10;
   localparam int ChromaW = 16;
   localparam int MeanW = 16;
   localparam int WeightW = 24;
   localparam int LimitW = 16;
   localparam int SqW = 2 * ChromaW;
   localparam int TermW = SqW + WeightW;
   localparam int SumW = TermW + 2;
   localparam int FracDrop = 32;
   localparam int DistHiW = SumW - FracDrop;
   localparam int QuoBitsPerStage = 4;
   localparam int DivStages = ChromaW / QuoBitsPerStage;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW = 24;

   localparam int ChanRed = 0;
   localparam int ChanGreen = 1;
   localparam int ChanBlue = 2;

   localparam logic [1:0] PairRedGreen = 2'd0;
   localparam logic [1:0] PairRedBlue = 2'd1;
   localparam logic [1:0] PairAll = 2'd2;

   localparam logic [PixW-1:0] MaskSkin = 8'd255;
   localparam logic [PixW-1:0] MaskOther = 8'd0;
   localparam logic [LimitW-1:0] DistMax = 16'hFFFF;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_PAIR_MODE = 3'd0,
      CSR_RED_MEAN = 3'd1,
      CSR_GREEN_MEAN = 3'd2,
      CSR_BLUE_MEAN = 3'd3,
      CSR_RED_WEIGHT = 3'd4,
      CSR_GREEN_WEIGHT = 3'd5,
      CSR_BLUE_WEIGHT = 3'd6,
      CSR_DIST_LIMIT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0] pair_mode;
      logic [NumChan-1:0][MeanW-1:0] mean;
      logic [NumChan-1:0][WeightW-1:0] weight;
      logic [LimitW-1:0] distance_limit;
   } cfg_type;

   typedef struct packed {
      logic [DenW-1:0] rem;
      logic [ChromaW-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic valid;
      logic [DenW-1:0] denom;
      div_lane_type [NumChan-1:0] lane;
   } div_data_type;

   // Restoring division, a few quotient bits per call. The remainder always
   // stays below the divisor, so doubling it never needs more than one extra bit.
   function automatic div_lane_type div_steps(input div_lane_type lane,
                                              input logic [DenW-1:0] denom);
      div_lane_type res;
      logic [DenW:0] wide;
      res = lane;
      for (int k = 0; k < QuoBitsPerStage; k++) begin
         wide = {res.rem, 1'b0};
         if (wide >= {1'b0, denom}) begin
            wide = wide - {1'b0, denom};
            res.rem = wide[DenW-1:0];
            res.quo = {res.quo[ChromaW-2:0], 1'b1};
         end else begin
            res.rem = wide[DenW-1:0];
            res.quo = {res.quo[ChromaW-2:0], 1'b0};
         end
      end
      return res;
   endfunction

endpackage

FILE: rtl/cgsc_csr.sv
// Configuration register file of the skin classifier.
module cgsc_csr
   import cgsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CsrIndexW-1:0] wr_index,
   input  logic [CsrDataW-1:0]  wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(wr_index))
            CSR_PAIR_MODE:    cfg_in.pair_mode = wr_data[1:0];
            CSR_RED_MEAN:     cfg_in.mean[ChanRed] = wr_data[MeanW-1:0];
            CSR_GREEN_MEAN:   cfg_in.mean[ChanGreen] = wr_data[MeanW-1:0];
            CSR_BLUE_MEAN:    cfg_in.mean[ChanBlue] = wr_data[MeanW-1:0];
            CSR_RED_WEIGHT:   cfg_in.weight[ChanRed] = wr_data[WeightW-1:0];
            CSR_GREEN_WEIGHT: cfg_in.weight[ChanGreen] = wr_data[WeightW-1:0];
            CSR_BLUE_WEIGHT:  cfg_in.weight[ChanBlue] = wr_data[WeightW-1:0];
            CSR_DIST_LIMIT:   cfg_in.distance_limit = wr_data[LimitW-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pair_mode: PairAll, mean: '0, weight: '0, distance_limit: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/cgsc_div_stage.sv
// One pipelined divider stage: four quotient bits for each of the three channels.
module cgsc_div_stage
   import cgsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  div_data_type prev_stage,
   output div_data_type next_stage
);

   div_data_type stage_ff;
   div_data_type stage_in;

   always_comb begin
      stage_in = prev_stage;
      for (int c = 0; c < NumChan; c++) begin
         stage_in.lane[c] = div_steps(prev_stage.lane[c], prev_stage.denom);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.denom <= stage_in.denom;
         stage_ff.lane <= stage_in.lane;
      end
   end

   assign next_stage = stage_ff;

   // A partial remainder at or above the divisor means a quotient bit was lost.
   a_rem_below_denom: assert property (@(posedge clock) disable iff (reset)
      stage_ff.valid |-> (stage_ff.lane[ChanRed].rem < stage_ff.denom) &&
                         (stage_ff.lane[ChanGreen].rem < stage_ff.denom) &&
                         (stage_ff.lane[ChanBlue].rem < stage_ff.denom))
      else $error("divider remainder not below divisor");

endmodule

FILE: rtl/cgsc_distance.sv
// Weighted squared distance, saturation and threshold compare pipeline.
module cgsc_distance
   import cgsc_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  cfg_type                          cfg,
   input  logic                             valid_in,
   input  logic [NumChan-1:0][ChromaW-1:0]  chroma,
   output logic                             valid_out,
   output logic                             skin
);

   logic                          sq_valid_ff;
   logic [NumChan-1:0][SqW-1:0]   sq_ff;
   logic [NumChan-1:0][SqW-1:0]   sq_in;
   logic [NumChan-1:0][ChromaW-1:0] diff;

   logic                          wt_valid_ff;
   logic [NumChan-1:0][TermW-1:0] wt_ff;
   logic [NumChan-1:0][TermW-1:0] wt_in;

   logic                          sum_valid_ff;
   logic [SumW-1:0]               sum_ff;
   logic [SumW-1:0]               sum_in;
   logic                          use_green;
   logic                          use_blue;

   logic                          cmp_valid_ff;
   logic                          skin_ff;
   logic                          skin_in;
   logic [DistHiW-1:0]            dist_hi;
   logic [LimitW-1:0]             dist_sat;

   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         diff[c] = (chroma[c] >= cfg.mean[c]) ? chroma[c] - cfg.mean[c]
                                              : cfg.mean[c] - chroma[c];
         sq_in[c] = SqW'(diff[c]) * SqW'(diff[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         wt_in[c] = TermW'(sq_ff[c]) * TermW'(cfg.weight[c]);
      end
   end

   // Encoding 3 of the mode falls through to all three channels.
   assign use_green = (cfg.pair_mode != PairRedBlue);
   assign use_blue = (cfg.pair_mode != PairRedGreen);
   assign sum_in = SumW'(wt_ff[ChanRed])
                 + (use_green ? SumW'(wt_ff[ChanGreen]) : '0)
                 + (use_blue ? SumW'(wt_ff[ChanBlue]) : '0);

   assign dist_hi = sum_ff[SumW-1:FracDrop];
   assign dist_sat = (|dist_hi[DistHiW-1:LimitW]) ? DistMax : dist_hi[LimitW-1:0];
   assign skin_in = (dist_sat < cfg.distance_limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         wt_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff <= valid_in;
         wt_valid_ff <= sq_valid_ff;
         sum_valid_ff <= wt_valid_ff;
         cmp_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
         wt_ff <= wt_in;
         sum_ff <= sum_in;
         skin_ff <= skin_in;
      end
   end

   assign valid_out = cmp_valid_ff;
   assign skin = skin_ff;

   // With a zero limit nothing can be skin.
   a_zero_limit: assert property (@(posedge clock) disable iff (reset)
      (cmp_valid_ff && cfg.distance_limit == '0) |-> !skin_ff)
      else $error("skin flagged with zero distance limit");

   // A result can only be skin if the saturated distance is below the limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (sum_valid_ff && en && (|dist_hi[DistHiW-1:LimitW])) |=> !skin_ff)
      else $error("saturated distance classified as skin");

endmodule

FILE: rtl/chromaticity_gaussian_skin_classifier_core.sv
// Pipeline registers from request acceptance to rsp_valid: entry, four divider
// stages of four quotient bits each, square, weight multiply, sum, compare.
// Throughput: one pixel per cycle; the whole pipeline holds when the output
// register is full and not taken, so req_ready follows rsp_ready.
// Reset clears every stage valid bit and loads pair_mode 2 with all other
// configuration registers zero. Configuration writes are taken every cycle.
module chromaticity_gaussian_skin_classifier_core
   import cgsc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PixW-1:0]      req_red,
   input  logic [PixW-1:0]      req_green,
   input  logic [PixW-1:0]      req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PixW-1:0]      rsp_mask_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   logic                            adv;
   cfg_type                         cfg;
   div_data_type                    entry_ff;
   div_data_type                    entry_in;
   div_data_type                    div_q [0:DivStages];
   logic [NumChan-1:0][ChromaW-1:0] chroma;
   logic                            dist_valid;
   logic                            dist_skin;

   assign csr_ready = 1'b1;

   cgsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Every stage moves together; an empty or draining output lets it advance.
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      entry_in.valid = req_valid;
      entry_in.denom = DenW'(req_red) + DenW'(req_green) + DenW'(req_blue) + DenW'(1);
      entry_in.lane[ChanRed] = '{rem: DenW'(req_red), quo: '0};
      entry_in.lane[ChanGreen] = '{rem: DenW'(req_green), quo: '0};
      entry_in.lane[ChanBlue] = '{rem: DenW'(req_blue), quo: '0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (adv) begin
         entry_ff.valid <= entry_in.valid;
      end
      if (adv) begin
         entry_ff.denom <= entry_in.denom;
         entry_ff.lane <= entry_in.lane;
      end
   end

   assign div_q[0] = entry_ff;

   for (genvar i = 0; i < DivStages; i++) begin : g_div
      cgsc_div_stage u_div_stage (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_stage (div_q[i]),
         .next_stage (div_q[i+1])
      );
   end

   always_comb begin
      for (int c = 0; c < NumChan; c++) begin
         chroma[c] = div_q[DivStages].lane[c].quo;
      end
   end

   cgsc_distance u_distance (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .cfg       (cfg),
      .valid_in  (div_q[DivStages].valid),
      .chroma    (chroma),
      .valid_out (dist_valid),
      .skin      (dist_skin)
   );

   assign rsp_valid = dist_valid;
   assign rsp_mask_value = dist_skin ? MaskSkin : MaskOther;

   // A request is only taken while the pipeline is free to advance.
   a_req_needs_adv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
      else $error("request accepted while output stalled");

   // A stalled output must keep the pipeline, and thus the entry stage, frozen.
   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(entry_ff.valid))
      else $error("entry stage moved during output stall");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the chromaticity Gaussian skin classifier core.
`timescale 1ns / 1ps

module testbench;
   import cgsc_pkg::*;

   localparam int ResetCycles = 7;
   localparam int DrainCycles = 16;
   localparam int RandomPhases = 12;
   localparam int PixelsPerPhase = 155;
   localparam int CycleLimit = 200000;
   localparam int MaxReports = 10;

   typedef struct packed {
      logic [PixW-1:0] red;
      logic [PixW-1:0] green;
      logic [PixW-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type px;
      logic [PixW-1:0] mask;
   } mask_entry_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PixW-1:0] req_red = '0;
   logic [PixW-1:0] req_green = '0;
   logic [PixW-1:0] req_blue = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PixW-1:0] rsp_mask_value;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIndexW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   pixel_type pixel_queue[$];
   mask_entry_type expected_masks[$];
   cfg_type active_cfg;
   logic req_accepted = 1'b0;
   logic rsp_taken = 1'b0;
   bit pixel_idle = 1'b1;
   bit stall_idle = 1'b1;
   int pixel_gap = 0;
   int rsp_stall = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   chromaticity_gaussian_skin_classifier_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mask_value(rsp_mask_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [ChromaW-1:0] chroma_q16(logic [PixW-1:0] comp,
                                                     logic [DenW-1:0] denom);
      return ChromaW'({comp, 16'h0000} / denom);
   endfunction

   function automatic logic [TermW-1:0] chroma_penalty(logic [ChromaW-1:0] c,
                                                       logic [MeanW-1:0] mean,
                                                       logic [WeightW-1:0] weight);
      logic [TermW-1:0] diff;
      diff = (c >= mean) ? c - mean : mean - c;
      return diff * diff * TermW'(weight);
   endfunction

   // Full-precision weighted distance, cut to Q8.8 with saturation, then compared.
   function automatic logic [PixW-1:0] classify_pixel(pixel_type px, cfg_type cfg);
      logic [DenW-1:0] denom;
      logic [SumW-1:0] acc;
      logic [DistHiW-1:0] dist_hi;
      logic [LimitW-1:0] dist_q88;
      denom = DenW'(px.red) + DenW'(px.green) + DenW'(px.blue) + 1'b1;
      acc = SumW'(chroma_penalty(chroma_q16(px.red, denom), cfg.mean[ChanRed],
                                 cfg.weight[ChanRed]));
      if (cfg.pair_mode != PairRedBlue) begin
         acc = acc + SumW'(chroma_penalty(chroma_q16(px.green, denom),
                                          cfg.mean[ChanGreen], cfg.weight[ChanGreen]));
      end
      if (cfg.pair_mode != PairRedGreen) begin
         acc = acc + SumW'(chroma_penalty(chroma_q16(px.blue, denom),
                                          cfg.mean[ChanBlue], cfg.weight[ChanBlue]));
      end
      dist_hi = acc[SumW-1:FracDrop];
      dist_q88 = (dist_hi > DistHiW'(DistMax)) ? DistMax : dist_hi[LimitW-1:0];
      return (dist_q88 < cfg.distance_limit) ? MaskSkin : MaskOther;
   endfunction

   function automatic int draw_gap(bit idle_on);
      if (!idle_on || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // Bits above the register width are don't-care, so fill them with noise.
   function automatic logic [CsrDataW-1:0] noisy(logic [CsrDataW-1:0] value, int width);
      logic [CsrDataW-1:0] high;
      high = $urandom;
      return (high << width) | value;
   endfunction

   function automatic logic [PixW-1:0] extreme_level();
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         3: return 8'd255;
         default: return PixW'($urandom);
      endcase
   endfunction

   // Same scale on all channels keeps the chromaticity close to the anchor.
   function automatic logic [PixW-1:0] near_level(logic [PixW-1:0] level, int scale);
      int v;
      v = int'(level) * scale / 256 + $urandom_range(0, 6) - 3;
      if (v < 0) begin
         v = 0;
      end else if (v > 255) begin
         v = 255;
      end
      return PixW'(v);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_cfg(cfg_type cfg);
      write_reg(CSR_PAIR_MODE, noisy(CsrDataW'(cfg.pair_mode), 2));
      write_reg(CSR_RED_MEAN, noisy(CsrDataW'(cfg.mean[ChanRed]), MeanW));
      write_reg(CSR_GREEN_MEAN, noisy(CsrDataW'(cfg.mean[ChanGreen]), MeanW));
      write_reg(CSR_BLUE_MEAN, noisy(CsrDataW'(cfg.mean[ChanBlue]), MeanW));
      write_reg(CSR_RED_WEIGHT, cfg.weight[ChanRed]);
      write_reg(CSR_GREEN_WEIGHT, cfg.weight[ChanGreen]);
      write_reg(CSR_BLUE_WEIGHT, cfg.weight[ChanBlue]);
      write_reg(CSR_DIST_LIMIT, noisy(CsrDataW'(cfg.distance_limit), LimitW));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pixel_queue.size() != 0 || req_valid || expected_masks.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Request driver: holds each pixel until it is taken, then waits its gap.
   always @(negedge clock) begin
      pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pixel_gap > 0) begin
            pixel_gap--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            px = pixel_queue.pop_front();
            req_red <= px.red;
            req_green <= px.green;
            req_blue <= px.blue;
            req_valid <= 1'b1;
            pixel_gap = draw_gap(pixel_idle);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: a fresh stall is drawn after each taken result.
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_stall = draw_gap(stall_idle);
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mask_entry_type entry;
      pixel_type px;
      if (reset) begin
         active_cfg = '0;
         active_cfg.pair_mode = PairAll;
         req_accepted = 1'b0;
         rsp_taken = 1'b0;
      end else begin
         req_accepted = req_valid && req_ready;
         rsp_taken = rsp_valid && rsp_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PAIR_MODE: active_cfg.pair_mode = csr_wdata[1:0];
               CSR_RED_MEAN: active_cfg.mean[ChanRed] = csr_wdata[MeanW-1:0];
               CSR_GREEN_MEAN: active_cfg.mean[ChanGreen] = csr_wdata[MeanW-1:0];
               CSR_BLUE_MEAN: active_cfg.mean[ChanBlue] = csr_wdata[MeanW-1:0];
               CSR_RED_WEIGHT: active_cfg.weight[ChanRed] = csr_wdata[WeightW-1:0];
               CSR_GREEN_WEIGHT: active_cfg.weight[ChanGreen] = csr_wdata[WeightW-1:0];
               CSR_BLUE_WEIGHT: active_cfg.weight[ChanBlue] = csr_wdata[WeightW-1:0];
               CSR_DIST_LIMIT: active_cfg.distance_limit = csr_wdata[LimitW-1:0];
               default: ;
            endcase
         end
         if (req_accepted) begin
            px = {req_red, req_green, req_blue};
            entry.px = px;
            entry.mask = classify_pixel(px, active_cfg);
            expected_masks.push_back(entry);
         end
         if (rsp_taken) begin
            if (expected_masks.size() == 0) begin
               if (mismatch_count < MaxReports) begin
                  $display("unexpected result: mask %0d with no request pending",
                           rsp_mask_value);
               end
               mismatch_count++;
            end else begin
               entry = expected_masks.pop_front();
               if (rsp_mask_value !== entry.mask) begin
                  if (mismatch_count < MaxReports) begin
                     $display("mask mismatch for pixel (%0d,%0d,%0d): expected %0d, got %0d",
                              entry.px.red, entry.px.green, entry.px.blue,
                              entry.mask, rsp_mask_value);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      cfg_type cfg;
      pixel_type anchor;
      int kind;
      int scale;
      int level_sum;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_PAIR_MODE;
      csr_wdata = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration has a zero limit, so nothing may come out as skin.
      pixel_queue.push_back({8'd0, 8'd0, 8'd0});
      pixel_queue.push_back({8'd200, 8'd140, 8'd110});
      pixel_queue.push_back({8'd255, 8'd255, 8'd255});
      drain();

      // A typical skin model: mean near (0.45, 0.31, 0.24), unit sigma 0.05.
      cfg.pair_mode = PairAll;
      cfg.mean[ChanRed] = 16'd29491;
      cfg.mean[ChanGreen] = 16'd20316;
      cfg.mean[ChanBlue] = 16'd15729;
      cfg.weight[ChanRed] = 24'd102400;
      cfg.weight[ChanGreen] = 24'd102400;
      cfg.weight[ChanBlue] = 24'd102400;
      cfg.distance_limit = 16'd1024;
      program_cfg(cfg);
      pixel_queue.push_back({8'd0, 8'd0, 8'd0});
      pixel_queue.push_back({8'd255, 8'd255, 8'd255});
      pixel_queue.push_back({8'd255, 8'd0, 8'd0});
      pixel_queue.push_back({8'd0, 8'd255, 8'd0});
      pixel_queue.push_back({8'd0, 8'd0, 8'd255});
      pixel_queue.push_back({8'd1, 8'd0, 8'd0});
      pixel_queue.push_back({8'd0, 8'd0, 8'd1});
      pixel_queue.push_back({8'h55, 8'hAA, 8'h55});
      pixel_queue.push_back({8'hAA, 8'h55, 8'hAA});
      pixel_queue.push_back({8'd200, 8'd140, 8'd110});
      pixel_queue.push_back({8'd180, 8'd120, 8'd90});
      pixel_queue.push_back({8'd170, 8'd85, 8'd42});
      drain();

      // The other channel selections, including the unused encoding.
      for (int m = 0; m < 4; m++) begin
         if (m != int'(PairAll)) begin
            cfg.pair_mode = 2'(m);
            program_cfg(cfg);
            pixel_queue.push_back({8'd200, 8'd140, 8'd110});
            pixel_queue.push_back({8'd200, 8'd60, 8'd200});
            pixel_queue.push_back({8'd200, 8'd200, 8'd60});
            drain();
         end
      end

      for (int k = 0; k < RandomPhases; k++) begin
         anchor = {PixW'($urandom_range(40, 255)), PixW'($urandom), PixW'($urandom)};
         level_sum = int'(anchor.red) + int'(anchor.green) + int'(anchor.blue) + 1;
         cfg.pair_mode = 2'($urandom_range(0, 3));
         cfg.mean[ChanRed] = chroma_q16(anchor.red, DenW'(level_sum));
         cfg.mean[ChanGreen] = chroma_q16(anchor.green, DenW'(level_sum));
         cfg.mean[ChanBlue] = chroma_q16(anchor.blue, DenW'(level_sum));
         for (int c = 0; c < NumChan; c++) begin
            cfg.weight[c] = WeightW'($urandom_range(2000, 600000));
         end
         cfg.distance_limit = LimitW'($urandom_range(0, 3000));
         case (k)
            0: begin
               // Saturated distance against the largest limit.
               cfg.pair_mode = PairAll;
               cfg.mean = {NumChan{16'hFFFF}};
               cfg.weight = {NumChan{24'hFFFFFF}};
               cfg.distance_limit = 16'hFFFF;
            end
            1: begin
               cfg.pair_mode = PairRedGreen;
               cfg.mean = '0;
               cfg.weight = '0;
               cfg.distance_limit = 16'hFFFF;
            end
            2: begin
               cfg.pair_mode = PairRedBlue;
               cfg.mean = '0;
               cfg.weight = {NumChan{24'hFFFFFF}};
               cfg.distance_limit = 16'd1;
            end
            default: begin
               if (k % 4 == 3) begin
                  for (int c = 0; c < NumChan; c++) begin
                     cfg.mean[c] = MeanW'($urandom);
                     cfg.weight[c] = WeightW'($urandom >> $urandom_range(0, 31));
                  end
                  cfg.distance_limit = LimitW'($urandom);
               end
            end
         endcase
         pixel_idle = ($urandom_range(0, 3) != 0);
         stall_idle = ($urandom_range(0, 3) != 0);
         program_cfg(cfg);
         for (int n = 0; n < PixelsPerPhase; n++) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
               scale = $urandom_range(64, 256);
               pixel_queue.push_back({near_level(anchor.red, scale),
                                      near_level(anchor.green, scale),
                                      near_level(anchor.blue, scale)});
            end else if (kind < 17) begin
               pixel_queue.push_back({PixW'($urandom), PixW'($urandom), PixW'($urandom)});
            end else begin
               pixel_queue.push_back({extreme_level(), extreme_level(), extreme_level()});
            end
         end
         drain();
      end

      if (mismatch_count == 0 && expected_masks.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
